[design/bsm_pkg.sv]
// Shared types and codes for the bounding sphere merge block.
package bsm_pkg;

	// result action codes
	typedef enum logic [1:0] {
		ACT_LOAD  = 2'd0,
		ACT_KEEP  = 2'd1,
		ACT_REPL  = 2'd2,
		ACT_MERGE = 2'd3
	} action_t;

	// sequencer states, one-hot
	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_DIFF  = 8'b0000_0010,
		ST_SQR   = 8'b0000_0100,
		ST_SQRT  = 8'b0000_1000,
		ST_MUL   = 8'b0001_0000,
		ST_DIV   = 8'b0010_0000,
		ST_AXIS  = 8'b0100_0000,
		ST_OUT   = 8'b1000_0000
	} state_t;

endpackage

[design/bounding_sphere_merge.sv]
// Top level: running bounding sphere with bit-serial square root and division.
// A load's result is registered in the cycle after it is accepted. When one
// sphere contains the other, the item takes W+1 step squares and a W+2 step root;
// a merge adds a W+1 step multiply and a 2W+2 step divide per axis.
// One item is worked at a time; the next is taken once the result is taken.
// Reset clears the held sphere to the zero sphere at the origin.
module bounding_sphere_merge #(
	parameter int COORD_WIDTH = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [COORD_WIDTH-1:0] sphere_x,
	input  logic signed [COORD_WIDTH-1:0] sphere_y,
	input  logic signed [COORD_WIDTH-1:0] sphere_z,
	input  logic        [COORD_WIDTH-2:0] sphere_radius,
	input  logic                          start_list,
	input  logic                          last_sphere,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [COORD_WIDTH-1:0] bound_x,
	output logic signed [COORD_WIDTH-1:0] bound_y,
	output logic signed [COORD_WIDTH-1:0] bound_z,
	output logic        [COORD_WIDTH-2:0] bound_radius,
	output bsm_pkg::action_t              merge_action,
	output logic                          radius_clipped,
	output logic                          list_done
);
	import bsm_pkg::*;

	localparam int W   = COORD_WIDTH;
	localparam int DW  = W + 1;          // difference magnitude width
	localparam int SQW = 2 * DW + 2;     // sum of three squares
	localparam int RTW = DW + 1;         // root width
	localparam int PW  = 2 * DW;         // product width
	localparam int CW  = $clog2(SQW + 1);

	state_t state_q;
	logic [CW-1:0] cnt_q;
	logic [1:0]    ax_q;

	// captured item
	logic signed [W-1:0] x_q, y_q, z_q;
	logic [W-2:0]        r_q;
	logic                last_q;
	// held bound
	logic signed [W-1:0] hx_q, hy_q, hz_q;
	logic [W-2:0]        hr_q;

	// per-axis differences
	logic [DW-1:0] m_q [3];
	logic          sn_q [3];
	logic [DW-1:0] drm_q;
	logic          drn_q;

	// serial square / multiply: shift-add
	logic [PW-1:0]  acc_q;
	logic [DW-1:0]  mplr_q;
	logic [SQW-1:0] d2_q;

	// serial root
	logic [SQW-1:0] rem_q;
	logic [SQW-1:0] rad_q;
	logic [RTW-1:0] root_q;

	// serial divide
	logic [PW-1:0]  num_q;
	logic [RTW:0]   drem_q;
	logic [PW-1:0]  quo_q;

	// output register
	logic out_full_q;
	logic signed [W-1:0] ox_q, oy_q, oz_q;
	logic [W-2:0] or_q;
	action_t oact_q;
	logic oclip_q, olast_q;

	logic in_acc, out_acc;
	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;
	assign in_stall = (state_q != ST_IDLE) || out_full_q;

	// current axis selections
	logic signed [W-1:0] c_sel, hc_sel;
	logic [DW-1:0] m_sel;
	logic          sn_sel;
	always_comb begin
		unique case (ax_q)
			2'd0: begin c_sel = x_q; hc_sel = hx_q; end
			2'd1: begin c_sel = y_q; hc_sel = hy_q; end
			default: begin c_sel = z_q; hc_sel = hz_q; end
		endcase
		m_sel  = m_q[ax_q];
		sn_sel = sn_q[ax_q];
	end

	// differences
	logic signed [W:0] dx, dy, dz, dr;
	always_comb begin
		dx = {x_q[W-1], x_q} - {hx_q[W-1], hx_q};
		dy = {y_q[W-1], y_q} - {hy_q[W-1], hy_q};
		dz = {z_q[W-1], z_q} - {hz_q[W-1], hz_q};
		dr = {2'b00, r_q} - {2'b00, hr_q};
	end

	// shift-add step
	logic [PW-1:0] acc_nx;
	assign acc_nx = mplr_q[0] ? acc_q + (PW'(m_sel) << (DW - 1)) : acc_q;

	// root step (radix 2, two bits of radicand per step)
	logic [SQW-1:0] rem_sh, trial;
	logic [RTW-1:0] root_sh;
	assign rem_sh  = {rem_q[SQW-3:0], rad_q[SQW-1:SQW-2]};
	assign root_sh = {root_q[RTW-2:0], 1'b0};
	assign trial   = SQW'({root_sh, 1'b1});

	// divide step
	logic [RTW:0] drem_sh;
	assign drem_sh = {drem_q[RTW-1:0], num_q[PW-1]};

	// axis result
	logic signed [W+2:0] qs, sum, hh;
	logic signed [W-1:0] cl;
	always_comb begin
		qs = (sn_sel != drn_q) ? -$signed((W+3)'(quo_q)) : $signed((W+3)'(quo_q));
		sum = $signed((W+3)'(c_sel)) + $signed((W+3)'(hc_sel)) + qs;
		hh = sum >>> 1;
		if (hh > $signed((W+3)'({1'b0, {(W-1){1'b1}}})))
			cl = {1'b0, {(W-1){1'b1}}};
		else if (hh < -$signed((W+3)'({1'b0, {(W-1){1'b1}}})) - 1)
			cl = {1'b1, {(W-1){1'b0}}};
		else
			cl = W'(hh);
	end

	// merged radius
	logic [RTW+1:0] nr;
	assign nr = ({3'b000, r_q} + {3'b000, hr_q} + {1'b0, root_q}) >> 1;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			ax_q <= '0;
			out_full_q <= 1'b0;
			hx_q <= '0; hy_q <= '0; hz_q <= '0; hr_q <= '0;
		end else begin
			if (out_acc)
				out_full_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						x_q <= sphere_x; y_q <= sphere_y; z_q <= sphere_z;
						r_q <= sphere_radius; last_q <= last_sphere;
						if (start_list) begin
							hx_q <= sphere_x; hy_q <= sphere_y; hz_q <= sphere_z;
							hr_q <= sphere_radius;
							ox_q <= sphere_x; oy_q <= sphere_y; oz_q <= sphere_z;
							or_q <= sphere_radius; oact_q <= ACT_LOAD;
							oclip_q <= 1'b0; olast_q <= last_sphere;
							out_full_q <= 1'b1;
						end else
							state_q <= ST_DIFF;
					end
				end
				ST_DIFF: begin
					m_q[0] <= dx[W] ? DW'(-dx) : DW'(dx); sn_q[0] <= dx[W];
					m_q[1] <= dy[W] ? DW'(-dy) : DW'(dy); sn_q[1] <= dy[W];
					m_q[2] <= dz[W] ? DW'(-dz) : DW'(dz); sn_q[2] <= dz[W];
					drm_q <= dr[W] ? DW'(-dr) : DW'(dr); drn_q <= dr[W];
					d2_q <= '0;
					ax_q <= '0;
					acc_q <= '0;
					mplr_q <= dx[W] ? DW'(-dx) : DW'(dx);
					cnt_q <= '0;
					state_q <= ST_SQR;
				end
				ST_SQR: begin
					// one multiplier bit per cycle
					if (cnt_q == CW'(DW - 1)) begin
						d2_q <= d2_q + SQW'(acc_nx);
						acc_q <= '0;
						cnt_q <= '0;
						if (ax_q == 2'd2) begin
							state_q <= ST_SQRT;
							rem_q <= '0; root_q <= '0;
						end else begin
							ax_q <= ax_q + 2'd1;
							mplr_q <= m_q[ax_q + 2'd1];
						end
					end else begin
						acc_q <= acc_nx >> 1;
						mplr_q <= mplr_q >> 1;
						cnt_q <= cnt_q + 1'b1;
					end
					if (cnt_q == CW'(DW - 1) && ax_q == 2'd2)
						rad_q <= d2_q + SQW'(acc_nx);
				end
				ST_SQRT: begin
					if (cnt_q == CW'(RTW)) begin
						// d2 > dr^2 exactly when root > |dr|, or root == |dr| with a remainder
						if (root_q > RTW'(drm_q) || (root_q == RTW'(drm_q) && rem_q != '0)) begin
							cnt_q <= '0; ax_q <= '0; acc_q <= '0;
							mplr_q <= drm_q;
							state_q <= ST_MUL;
						end else begin
							// contained or touching
							if (r_q > hr_q) begin
								hx_q <= x_q; hy_q <= y_q; hz_q <= z_q; hr_q <= r_q;
								ox_q <= x_q; oy_q <= y_q; oz_q <= z_q; or_q <= r_q;
								oact_q <= ACT_REPL;
							end else begin
								ox_q <= hx_q; oy_q <= hy_q; oz_q <= hz_q; or_q <= hr_q;
								oact_q <= ACT_KEEP;
							end
							oclip_q <= 1'b0; olast_q <= last_q;
							out_full_q <= 1'b1;
							state_q <= ST_IDLE;
						end
					end else begin
						if (rem_sh >= trial) begin
							rem_q <= rem_sh - trial;
							root_q <= root_sh | RTW'(1);
						end else begin
							rem_q <= rem_sh;
							root_q <= root_sh;
						end
						rad_q <= rad_q << 2;
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_MUL: begin
					// |diff| * |dr|, one bit per cycle
					if (cnt_q == CW'(DW - 1)) begin
						num_q <= acc_nx; drem_q <= '0; quo_q <= '0;
						cnt_q <= '0;
						state_q <= ST_DIV;
					end else begin
						acc_q <= acc_nx >> 1;
						mplr_q <= mplr_q >> 1;
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DIV: begin
					// restoring division, one quotient bit per cycle
					num_q <= num_q << 1;
					if (drem_sh >= {1'b0, root_q}) begin
						drem_q <= drem_sh - {1'b0, root_q};
						quo_q <= {quo_q[PW-2:0], 1'b1};
					end else begin
						drem_q <= drem_sh;
						quo_q <= {quo_q[PW-2:0], 1'b0};
					end
					if (cnt_q == CW'(PW - 1)) begin
						cnt_q <= '0;
						state_q <= ST_AXIS;
					end else
						cnt_q <= cnt_q + 1'b1;
				end
				ST_AXIS: begin
					unique case (ax_q)
						2'd0: ox_q <= cl;
						2'd1: oy_q <= cl;
						default: oz_q <= cl;
					endcase
					if (ax_q == 2'd2)
						state_q <= ST_OUT;
					else begin
						ax_q <= ax_q + 2'd1;
						acc_q <= '0;
						mplr_q <= drm_q;
						state_q <= ST_MUL;
					end
				end
				ST_OUT: begin
					if (nr > (RTW+2)'({(W-1){1'b1}})) begin
						or_q <= {(W-1){1'b1}}; hr_q <= {(W-1){1'b1}};
						oclip_q <= 1'b1;
					end else begin
						or_q <= (W-1)'(nr); hr_q <= (W-1)'(nr);
						oclip_q <= 1'b0;
					end
					hx_q <= ox_q; hy_q <= oy_q; hz_q <= oz_q;
					oact_q <= ACT_MERGE; olast_q <= last_q;
					out_full_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid      = out_full_q;
	assign bound_x        = ox_q;
	assign bound_y        = oy_q;
	assign bound_z        = oz_q;
	assign bound_radius   = or_q;
	assign merge_action   = oact_q;
	assign radius_clipped = oclip_q;
	assign list_done      = olast_q;

endmodule

[verif/bsm_checker.sv]
// Checker for the bounding sphere merge block: models the held sphere and compares results.
module bsm_checker #(
	parameter int CW = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  logic signed [CW-1:0] sphere_x,
	input  logic signed [CW-1:0] sphere_y,
	input  logic signed [CW-1:0] sphere_z,
	input  logic        [CW-2:0] sphere_radius,
	input  logic                 start_list,
	input  logic                 last_sphere,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  logic signed [CW-1:0] bound_x,
	input  logic signed [CW-1:0] bound_y,
	input  logic signed [CW-1:0] bound_z,
	input  logic        [CW-2:0] bound_radius,
	input  bsm_pkg::action_t     merge_action,
	input  logic                 radius_clipped,
	input  logic                 list_done,
	output int                   fail_count,
	output int                   pending
);
	import bsm_pkg::*;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
		logic [CW-2:0]        r;
		action_t              act;
		logic                 clip;
		logic                 done;
	} bound_t;

	localparam longint CMAX = (64'sd1 <<< (CW-1)) - 1;
	localparam longint CMIN = -CMAX - 1;

	bound_t      bound_q[$];
	longint      held_x, held_y, held_z;
	longint      held_r;

	assign pending = bound_q.size();

	// floor square root of a wide sum
	function automatic longint root_floor(logic [127:0] v);
		logic [127:0] res;
		logic [127:0] cand;
		res = 0;
		for (int b = 40; b >= 0; b--) begin
			cand = res | (128'd1 << b);
			if (cand * cand <= v) res = cand;
		end
		return longint'(res);
	endfunction

	// one axis of the merged center
	function automatic longint axis_center(longint c, longint hc, longint drm, bit rneg,
			longint d);
		longint diff, qm, q, s, h;
		diff = c - hc;
		qm = ((diff < 0 ? -diff : diff) * drm) / d;
		q = ((diff < 0) != rneg) ? -qm : qm;
		s = c + hc + q;
		h = s >= 0 ? s / 2 : -((-s + 1) / 2);
		if (h > CMAX) h = CMAX;
		if (h < CMIN) h = CMIN;
		return h;
	endfunction

	// expected result of one accepted sphere
	function automatic bound_t merge_sphere(longint x, longint y, longint z, longint r,
			bit start, bit last);
		bound_t       e;
		longint       dr, drm, d, nr;
		logic [127:0] d2, dr2;
		e.clip = 0;
		e.done = last;
		if (start) begin
			held_x = x; held_y = y; held_z = z; held_r = r;
			e.act = ACT_LOAD;
		end else begin
			dr = r - held_r;
			drm = dr < 0 ? -dr : dr;
			dr2 = 128'(drm) * 128'(drm);
			d2 = 128'((x - held_x) * (x - held_x)) + 128'((y - held_y) * (y - held_y))
				+ 128'((z - held_z) * (z - held_z));
			if (d2 > dr2) begin
				d = root_floor(d2);
				nr = (r + held_r + d) >>> 1;
				if (nr > CMAX) begin
					nr = CMAX;
					e.clip = 1;
				end
				held_x = axis_center(x, held_x, drm, dr < 0, d);
				held_y = axis_center(y, held_y, drm, dr < 0, d);
				held_z = axis_center(z, held_z, drm, dr < 0, d);
				held_r = nr;
				e.act = ACT_MERGE;
			end else if (r > held_r) begin
				held_x = x; held_y = y; held_z = z; held_r = r;
				e.act = ACT_REPL;
			end else begin
				e.act = ACT_KEEP;
			end
		end
		e.x = held_x[CW-1:0];
		e.y = held_y[CW-1:0];
		e.z = held_z[CW-1:0];
		e.r = held_r[CW-2:0];
		return e;
	endfunction

	// watch both channels
	always @(posedge clk or negedge arst_n) begin
		bound_t e;
		if (!arst_n) begin
			held_x = 0; held_y = 0; held_z = 0; held_r = 0;
			fail_count <= 0;
			bound_q.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (bound_q.size() == 0) begin
					$display("%0t: result with none expected", $time);
					fail_count <= fail_count + 1;
				end else begin
					e = bound_q.pop_front();
					if (e !== {bound_x, bound_y, bound_z, bound_radius, merge_action,
							radius_clipped, list_done}) begin
						$display("%0t: mismatch exp x=%0d y=%0d z=%0d r=%0d a=%0d c=%0b l=%0b",
							$time, e.x, e.y, e.z, e.r, e.act, e.clip, e.done);
						$display("%0t:          got x=%0d y=%0d z=%0d r=%0d a=%0d c=%0b l=%0b",
							$time, bound_x, bound_y, bound_z, bound_radius, merge_action,
							radius_clipped, list_done);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (in_valid && !in_stall)
				bound_q.push_back(merge_sphere(sphere_x, sphere_y, sphere_z, sphere_radius,
					start_list, last_sphere));
		end
	end

endmodule

[verif/testbench.sv]
// Testbench top: drives sphere lists into the merge block and gives the verdict.
module testbench;
	import bsm_pkg::*;

	localparam int CW = 24;
	localparam int LIMIT = 1500000;

	logic                 clk, arst_n;
	logic                 in_valid, in_stall, out_valid, out_stall;
	logic signed [CW-1:0] sphere_x, sphere_y, sphere_z, bound_x, bound_y, bound_z;
	logic        [CW-2:0] sphere_radius, bound_radius;
	logic                 start_list, last_sphere, radius_clipped, list_done;
	action_t              merge_action;
	int                   fail_count, pending;
	int                   cycles;
	bit                   hold_off;

	bounding_sphere_merge #(.COORD_WIDTH(CW)) u_top (.*);

	bsm_checker #(.CW(CW)) u_checker (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// cycle limit
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// receiver stall pattern, with one long hold-off on request
	initial begin
		int mode;
		bit held;
		held = 0;
		out_stall = 0;
		forever begin
			@(negedge clk);
			if (hold_off && !held) begin
				held = 1;
				out_stall <= 1;
				repeat (400) @(negedge clk);
			end else begin
				mode = (cycles / 3000) % 3;
				if (mode == 0) out_stall <= 0;
				else if (mode == 1) out_stall <= ($urandom_range(0, 3) == 0);
				else out_stall <= ($urandom_range(0, 1) == 0);
			end
		end
	end

	// offer one sphere and wait for it to be taken
	task automatic send_sphere(logic signed [CW-1:0] x, y, z, logic [CW-2:0] r, bit s, l);
		in_valid <= 1;
		sphere_x <= x; sphere_y <= y; sphere_z <= z;
		sphere_radius <= r; start_list <= s; last_sphere <= l;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic pause_sender();
		in_valid <= 0;
		repeat ($urandom_range(1, 12)) @(negedge clk);
	endtask

	function automatic logic signed [CW-1:0] rand_coord(int span);
		case ($urandom_range(0, 5))
			0: return CW'($urandom);
			1: return $urandom_range(0, 1) ? CW'((1 <<< (CW-1)) - 1) : CW'(-(1 <<< (CW-1)));
			default: return CW'($signed($urandom_range(0, 2*span)) - span);
		endcase
	endfunction

	function automatic logic [CW-2:0] rand_radius(int span);
		case ($urandom_range(0, 5))
			0: return (CW-1)'($urandom);
			1: return (CW-1)'((1 << (CW-1)) - 1);
			2: return '0;
			default: return (CW-1)'($urandom_range(0, span));
		endcase
	endfunction

	initial begin
		int n, len, span, burst;
		logic signed [CW-1:0] mx, mn;
		logic [CW-2:0] rmax;
		mx = CW'((1 <<< (CW-1)) - 1);
		mn = CW'(-(1 <<< (CW-1)));
		rmax = (CW-1)'((1 << (CW-1)) - 1);
		hold_off = 0;
		in_valid = 0;
		sphere_x = 0; sphere_y = 0; sphere_z = 0; sphere_radius = 0;
		start_list = 0; last_sphere = 0;
		arst_n = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: first item merged with the zero sphere, equal and touching spheres
		send_sphere(100, 0, 0, 50, 0, 0);
		send_sphere(100, 0, 0, 50, 0, 0);
		send_sphere(100, 0, 0, 60, 0, 0);
		send_sphere(110, 0, 0, 50, 0, 0);
		send_sphere(140, 0, 0, 100, 0, 0);
		send_sphere(0, 0, 0, 10, 1, 1);
		send_sphere(mx, mx, mx, rmax, 1, 0);
		send_sphere(mn, mn, mn, rmax, 0, 1);
		send_sphere(mn, mx, mn, 0, 1, 0);
		send_sphere(mx, mn, mx, 0, 0, 0);
		send_sphere(-5, -7, 3, 0, 0, 1);
		send_sphere(mx, mx, mx, 0, 1, 0);
		send_sphere(mn, mn, mn, rmax, 0, 1);
		send_sphere(-1, -1, -1, 1, 1, 0);
		send_sphere(-1, -1, -1, rmax, 0, 0);
		send_sphere(mx, 0, mn, 12345, 0, 1);

		// random lists in bursts; one long receiver hold-off partway
		n = 0;
		burst = 0;
		while (n < 650) begin
			if (n == 200) hold_off = 1;
			span = $urandom_range(0, 3) == 0 ? 8000000 : $urandom_range(4, 40000);
			len = $urandom_range(1, 8);
			for (int i = 0; i < len; i++) begin
				send_sphere(rand_coord(span), rand_coord(span), rand_coord(span),
					rand_radius(span / 2), i == 0 ? ($urandom_range(0, 9) != 0)
					: ($urandom_range(0, 15) == 0), i == len - 1 || $urandom_range(0, 1));
				n++;
				if (burst == 0) begin
					burst = $urandom_range(0, 10);
					if ($urandom_range(0, 1)) pause_sender();
				end else burst--;
			end
		end
		in_valid <= 0;
		hold_off = 0;

		while (pending != 0) @(negedge clk);
		repeat (300) @(negedge clk);
		if (fail_count == 0) $display("TB_OK");
		else $display("TB_ERROR");
		$finish;
	end

endmodule
